### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Clocked concurrent checks with a synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/cirw_pkg.sv
// ----------------------------------------------------------------------------
// cirw_pkg
// Types and constants for the codec I2C register writer.
// ----------------------------------------------------------------------------
package cirw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS      = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [7:0]  DEV_ADDR_RESET   = 8'd52;
  localparam logic [7:0]  POLL_LIMIT_RESET = 8'd250;
  localparam logic [15:0] TICKS_RESET      = 16'd1;

  // Item kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Completion status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
  localparam logic [1:0] STATUS_D0_NACK   = 2'd2;
  localparam logic [1:0] STATUS_D1_NACK   = 2'd3;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  // One input item
  typedef struct packed {
    logic       cmd;
    logic [6:0] reg_addr;
    logic [8:0] reg_value;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl;
  } res_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  device_address_byte;
    logic [7:0]  ack_poll_limit;
    logic [15:0] ticks_per_phase;
  } cfg_t;

endpackage

### hw/rtl/cirw_engine.sv
// ----------------------------------------------------------------------------
// cirw_engine
// Bus phase sequencer: one tick per item, result formed from the current
// phase, state advanced when the item moves on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cirw_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  cirw_pkg::item_t item,
  input  cirw_pkg::cfg_t  cfg,
  output cirw_pkg::res_t  res
);
  import cirw_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START_A   = 5'd1,
    PH_START_B   = 5'd2,
    PH_START_C   = 5'd3,
    PH_BIT_SETUP = 5'd4,
    PH_BIT_HIGH  = 5'd5,
    PH_BIT_HOLD  = 5'd6,
    PH_ACK_SETUP = 5'd7,
    PH_ACK_HIGH  = 5'd8,
    PH_ACK_POLL  = 5'd9,
    PH_ACK_LOW   = 5'd10,
    PH_STOP_A    = 5'd11,
    PH_STOP_B    = 5'd12,
    PH_STOP_C    = 5'd13
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] payload_word, payload_word_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [1:0]  error_code, error_code_next;

  logic [15:0] tick_limit;
  logic [16:0] timer_inc;
  logic        elapsed;
  logic [15:0] timer_step;

  // Phase timer: zero ticks_per_phase counts as one
  assign tick_limit = (cfg.ticks_per_phase == '0) ? 16'd1 : cfg.ticks_per_phase;
  assign timer_inc  = {1'b0, phase_timer} + 17'd1;
  assign elapsed    = timer_inc >= {1'b0, tick_limit};
  assign timer_step = elapsed ? '0 : timer_inc[15:0];

  // Result and next state for this tick
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    byte_index_next   = byte_index;
    shift_byte_next   = shift_byte;
    payload_word_next = payload_word;
    poll_count_next   = poll_count;
    phase_timer_next  = phase_timer;
    error_code_next   = error_code;

    res.scl       = 1'b1;
    res.sda_out   = 1'b1;
    res.sda_drive = 1'b1;
    res.busy_res  = 1'b1;
    res.done_res  = 1'b0;
    res.status    = STATUS_OK;

    case (phase)
      PH_IDLE: begin
        res.busy_res = 1'b0;
        if (item.cmd == CMD_WRITE) begin
          payload_word_next = {item.reg_addr, item.reg_value};
          shift_byte_next   = cfg.device_address_byte;
          byte_index_next   = '0;
          bit_count_next    = '0;
          poll_count_next   = '0;
          phase_timer_next  = '0;
          error_code_next   = STATUS_OK;
          phase_next        = PH_START_A;
        end
      end
      PH_START_A: begin
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_START_B;
      end
      PH_START_B: begin
        res.sda_out      = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_START_C;
      end
      PH_START_C: begin
        res.scl          = 1'b0;
        res.sda_out      = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_BIT_SETUP;
      end
      PH_BIT_SETUP: begin
        res.scl          = 1'b0;
        res.sda_out      = shift_byte[7];
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        res.sda_out      = shift_byte[7];
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_BIT_HOLD;
      end
      PH_BIT_HOLD: begin
        res.scl          = 1'b0;
        res.sda_out      = shift_byte[7];
        phase_timer_next = timer_step;
        if (elapsed) begin
          if (bit_count == 3'd7) begin
            bit_count_next = '0;
            phase_next     = PH_ACK_SETUP;
          end else begin
            bit_count_next  = bit_count + 3'd1;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            phase_next      = PH_BIT_SETUP;
          end
        end
      end
      PH_ACK_SETUP: begin
        res.scl          = 1'b0;
        res.sda_drive    = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        res.sda_drive    = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) begin
          poll_count_next = '0;
          phase_next      = PH_ACK_POLL;
        end
      end
      PH_ACK_POLL: begin
        // low sample is the acknowledge
        res.sda_drive    = 1'b0;
        phase_timer_next = '0;
        if (!item.sda_in) begin
          phase_next = PH_ACK_LOW;
        end else if (poll_count >= cfg.ack_poll_limit) begin
          error_code_next = byte_index + 2'd1;
          phase_next      = PH_STOP_A;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      PH_ACK_LOW: begin
        res.scl          = 1'b0;
        res.sda_drive    = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) begin
          if (byte_index >= 2'd2) begin
            phase_next = PH_STOP_A;
          end else begin
            byte_index_next = byte_index + 2'd1;
            shift_byte_next = (byte_index == 2'd0) ? payload_word[15:8]
                                                   : payload_word[7:0];
            bit_count_next  = '0;
            phase_next      = PH_BIT_SETUP;
          end
        end
      end
      PH_STOP_A: begin
        res.scl          = 1'b0;
        res.sda_out      = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        res.sda_out      = 1'b0;
        phase_timer_next = timer_step;
        if (elapsed) phase_next = PH_STOP_C;
      end
      PH_STOP_C: begin
        phase_timer_next = timer_step;
        if (elapsed) begin
          res.done_res = 1'b1;
          res.status   = error_code;
          phase_next   = PH_IDLE;
        end
      end
      default: begin
        res.busy_res     = 1'b0;
        phase_timer_next = '0;
        phase_next       = PH_IDLE;
      end
    endcase

    // released line reads back high
    if (!res.sda_drive) res.sda_out = 1'b1;
  end

  // State registers, advanced once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      byte_index   <= '0;
      shift_byte   <= '0;
      payload_word <= '0;
      poll_count   <= '0;
      phase_timer  <= '0;
      error_code   <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      byte_index   <= byte_index_next;
      shift_byte   <= shift_byte_next;
      payload_word <= payload_word_next;
      poll_count   <= poll_count_next;
      phase_timer  <= phase_timer_next;
      error_code   <= error_code_next;
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_idle_timer_clear, clk, rst, phase == PH_IDLE, phase_timer == '0, "timer not clear in idle")
  `ASSERT_HOLDS(a_byte_index_range, clk, rst, byte_index != 2'd3, "byte index past third byte")
  `ASSERT_IMPLIES(a_status_with_done, clk, rst, res.status != STATUS_OK, res.done_res, "status without done")
  `ASSERT_IMPLIES(a_poll_bound, clk, rst, phase == PH_ACK_POLL, poll_count <= cfg.ack_poll_limit, "poll count over limit")

endmodule

### hw/rtl/cirw_out_buf.sv
// ----------------------------------------------------------------------------
// cirw_out_buf
// Two-entry output register with skid slot; ready toward the core is
// registered so the output stall never reaches the input combinationally.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cirw_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cirw_pkg::res_t push_res,
  output logic           push_ready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output cirw_pkg::res_t m_res
);
  import cirw_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;
  logic pop;

  assign pop        = main_valid && m_tready;
  assign push_ready = !skid_valid;
  assign m_tvalid   = main_valid;
  assign m_res      = main_res;

  // Control: skid drains first, new item lands in main when it frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (main_valid && !pop) skid_valid <= 1'b1;
      else main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_res <= skid_res;
    end else if (push) begin
      if (main_valid && !pop) skid_res <= push_res;
      else main_res <= push_res;
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_main, clk, rst, skid_valid, main_valid, "skid slot full with main empty")

endmodule

### hw/rtl/codec_i2c_register_writer_core.sv
// ----------------------------------------------------------------------------
// codec_i2c_register_writer_core
// Tick-driven I2C master that writes one 9-bit codec register value.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tuser: cmd; tdata: reg_addr, reg_value, sda_in
//  m_*       out  tvalid/tready      tdata: scl, sda_out, sda_drive, busy, done, status
//  cfg_*     in   cfg_we only        cfg_index, cfg_data
//
//  One tick item in, one result item out, one item per clock sustained while m_tready is high.
//  Each item passes the input register, then phase logic into the output register.
//  The output register has a skid slot, so s_tready depends only on registers.
//  rst is synchronous; it returns the sequencer to idle and loads config defaults.
//  Bus timing counts ticks, not clocks: stalls only delay ticks.
// ----------------------------------------------------------------------------
module codec_i2c_register_writer_core (
  input  logic                                clk,
  input  logic                                rst,
  // input ticks
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cirw_pkg::IN_DATA_W-1:0]      s_tdata,  // reg_addr[6:0], reg_value[15:7], sda_in[16]
  input  logic                                s_tuser,  // cmd[0]
  // results
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cirw_pkg::OUT_DATA_W-1:0]     m_tdata,  // scl, sda_out, sda_drive, busy_res, done_res, status[6:5]
  // configuration
  input  logic                                cfg_we,
  input  logic [cirw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cirw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cirw_pkg::*;

  cfg_t  cfg;
  logic  in_valid;
  item_t in_item;
  logic  out_ready;
  logic  advance;
  res_t  step_res;
  res_t  out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address_byte <= DEV_ADDR_RESET;
      cfg.ack_poll_limit      <= POLL_LIMIT_RESET;
      cfg.ticks_per_phase     <= TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR:   cfg.device_address_byte <= cfg_data[7:0];
        CFG_POLL_LIMIT: cfg.ack_poll_limit      <= cfg_data[7:0];
        CFG_TICKS:      cfg.ticks_per_phase     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  assign advance  = in_valid && out_ready;
  assign s_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd       <= s_tuser;
      in_item.reg_addr  <= s_tdata[6:0];
      in_item.reg_value <= s_tdata[15:7];
      in_item.sda_in    <= s_tdata[16];
    end
  end

  // Phase sequencer
  cirw_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  // Result register
  cirw_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_res   (step_res),
    .push_ready (out_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_res      (out_res)
  );

  assign m_tdata = {1'b0, out_res};

endmodule

### test/tb_codec_i2c_register_writer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_codec_i2c_register_writer_core
// Self-checking bench for the tick-driven I2C register writer.
// Every tick item sent is run through a local bus-phase predictor, which
// queues the expected line levels. Each result that leaves the block is
// checked field by field against the oldest queued entry. Directed writes
// cover default settings, a missing acknowledge on each byte, register
// extremes and requests while busy. Random writes with random acknowledge
// behavior, register changes between transactions and random idling on
// both streams follow.
// ----------------------------------------------------------------------------
module tb_codec_i2c_register_writer_core;
  import cirw_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_TICKS = 1300;

  // Bus sequencer phases, as tracked by the predictor
  typedef enum logic [4:0] {
    S_IDLE, S_STA_HI, S_STA_FALL, S_STA_LOW,
    S_BIT_SU, S_BIT_HI, S_BIT_HD,
    S_ACK_SU, S_ACK_SETTLE, S_ACK_POLL, S_ACK_LO,
    S_STO_LO, S_STO_RISE, S_STO_HI
  } bus_phase_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;  // reg_addr[6:0], reg_value[15:7], sda_in[16]
  logic                  s_tuser = 1'b0; // cmd[0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;  // scl, sda_out, sda_drive, busy_res, done_res, status[6:5]
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  codec_i2c_register_writer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor copy of configuration and sequencer state
  logic [7:0]  dev_byte;
  logic [7:0]  poll_limit;
  logic [15:0] phase_ticks;
  bus_phase_e  bp;
  logic [2:0]  bits_sent;
  logic [1:0]  byte_i;
  logic [7:0]  shifter;
  logic [15:0] payload;
  logic [7:0]  polls;
  logic [15:0] timer;
  logic [1:0]  err_code;

  res_t pending_levels[$];
  res_t got_lv, want_lv;

  int errors        = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int writes_begun  = 0;
  int done_ok       = 0;
  int done_nack[4]  = '{0, 0, 0, 0};
  int cfg_writes    = 0;
  int quiet         = 0;
  bit idle_on       = 1'b0;
  bit stall_on      = 1'b0;
  int stall_left    = 0;
  int stall_pick;

  // One tick of a timed phase; 1 when the phase is over
  function bit phase_over();
    int lim;
    lim = (phase_ticks == 16'd0) ? 1 : int'(phase_ticks);
    if (int'(timer) + 1 >= lim) begin
      timer = '0;
      return 1'b1;
    end
    timer = timer + 16'd1;
    return 1'b0;
  endfunction

  // Expected line levels for one tick; advances the predicted sequencer
  function res_t step_bus(logic cmd, logic [6:0] ra, logic [8:0] rv, logic sda);
    res_t r;
    logic bitv;
    r.scl       = 1'b1;
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b1;
    r.busy_res  = 1'b1;
    r.done_res  = 1'b0;
    r.status    = STATUS_OK;
    bitv        = shifter[7];
    case (bp)
      S_IDLE: begin
        r.busy_res = 1'b0;
        if (cmd == CMD_WRITE) begin
          payload   = {ra, rv[8], rv[7:0]};
          shifter   = dev_byte;
          byte_i    = '0;
          bits_sent = '0;
          polls     = '0;
          timer     = '0;
          err_code  = STATUS_OK;
          bp        = S_STA_HI;
          writes_begun++;
        end
      end
      S_STA_HI: if (phase_over()) bp = S_STA_FALL;
      S_STA_FALL: begin
        r.sda_out = 1'b0;
        if (phase_over()) bp = S_STA_LOW;
      end
      S_STA_LOW: begin
        r.scl = 1'b0; r.sda_out = 1'b0;
        if (phase_over()) bp = S_BIT_SU;
      end
      S_BIT_SU: begin
        r.scl = 1'b0; r.sda_out = bitv;
        if (phase_over()) bp = S_BIT_HI;
      end
      S_BIT_HI: begin
        r.sda_out = bitv;
        if (phase_over()) bp = S_BIT_HD;
      end
      S_BIT_HD: begin
        r.scl = 1'b0; r.sda_out = bitv;
        if (phase_over()) begin
          if (bits_sent == 3'd7) begin
            bits_sent = '0;
            bp = S_ACK_SU;
          end else begin
            bits_sent = bits_sent + 3'd1;
            shifter = shifter << 1;
            bp = S_BIT_SU;
          end
        end
      end
      S_ACK_SU: begin
        r.scl = 1'b0; r.sda_drive = 1'b0;
        if (phase_over()) bp = S_ACK_SETTLE;
      end
      S_ACK_SETTLE: begin
        r.sda_drive = 1'b0;
        if (phase_over()) begin
          polls = '0;
          bp = S_ACK_POLL;
        end
      end
      S_ACK_POLL: begin
        // not timed: one SDA sample per tick
        r.sda_drive = 1'b0;
        timer = '0;
        if (!sda) begin
          bp = S_ACK_LO;
        end else if (polls >= poll_limit) begin
          err_code = (byte_i == 2'd0) ? STATUS_ADDR_NACK :
                     (byte_i == 2'd1) ? STATUS_D0_NACK : STATUS_D1_NACK;
          bp = S_STO_LO;
        end else begin
          polls = polls + 8'd1;
        end
      end
      S_ACK_LO: begin
        r.scl = 1'b0; r.sda_drive = 1'b0;
        if (phase_over()) begin
          if (byte_i >= 2'd2) begin
            bp = S_STO_LO;
          end else begin
            byte_i = byte_i + 2'd1;
            shifter = (byte_i == 2'd1) ? payload[15:8] : payload[7:0];
            bits_sent = '0;
            bp = S_BIT_SU;
          end
        end
      end
      S_STO_LO: begin
        r.scl = 1'b0; r.sda_out = 1'b0;
        if (phase_over()) bp = S_STO_RISE;
      end
      S_STO_RISE: begin
        r.sda_out = 1'b0;
        if (phase_over()) bp = S_STO_HI;
      end
      S_STO_HI: begin
        if (phase_over()) begin
          r.done_res = 1'b1;
          r.status = err_code;
          if (err_code == STATUS_OK) done_ok++;
          else done_nack[err_code]++;
          bp = S_IDLE;
        end
      end
      default: begin
        r.busy_res = 1'b0;
        timer = '0;
        bp = S_IDLE;
      end
    endcase
    if (!r.sda_drive) r.sda_out = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    errors++;
    if (errors <= 20)
      $display("MISMATCH %s at result %0d: got %0d, want %0d",
               what, results_seen, got_v, want_v);
  endtask

  function int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!idle_on || p < 60) return 0;
    if (p < 88) return $urandom_range(1, 2);
    if (p < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Send one tick item; entered and left at a falling edge
  task automatic send_tick(logic cmd, logic [6:0] ra, logic [8:0] rv, logic sda);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, sda, rv, ra};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_levels.push_back(step_bus(cmd, ra, rv, sda));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every queued result has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEV_ADDR:   dev_byte    = val[7:0];
      CFG_POLL_LIMIT: poll_limit  = val[7:0];
      CFG_TICKS:      phase_ticks = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic idle_ticks(int n);
    repeat (n) send_tick(CMD_TICK, 7'($urandom_range(0, 127)),
                         9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
  endtask

  // One register write from request to stop. nack_byte 1..3 holds SDA high
  // in that byte's acknowledge poll; 0 draws every poll sample high with
  // probability hi_pct, so a byte may still run out its poll limit.
  task automatic run_write(logic [6:0] ra, logic [8:0] rv, int nack_byte,
                           int hi_pct, int pause_at);
    int n;
    logic sda;
    logic cmdv;
    n = 0;
    send_tick(CMD_WRITE, ra, rv, 1'($urandom_range(0, 1)));
    while (bp != S_IDLE) begin
      if (n == pause_at) wait_drained();
      if (bp == S_ACK_POLL)
        sda = (int'(byte_i) + 1 == nack_byte) ? 1'b1 : ($urandom_range(0, 99) < hi_pct);
      else
        sda = 1'($urandom_range(0, 1));
      // stray requests while busy must be ignored
      cmdv = ($urandom_range(0, 15) == 0) ? CMD_WRITE : CMD_TICK;
      send_tick(cmdv, 7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)), sda);
      n++;
    end
  endtask

  // Default settings, field extremes, busy requests
  task automatic test_default_write();
    run_write(7'h7F, 9'h1FF, 0, 0, -1);
    idle_ticks(2);
    run_write(7'h00, 9'h000, 0, 30, -1);
  endtask

  // Missing acknowledge on each byte, with the tightest and a loose limit
  task automatic test_nack_per_byte();
    cfg_write(CFG_POLL_LIMIT, 16'd0);
    run_write(7'h12, 9'h134, 1, 0, -1);
    run_write(7'h6A, 9'h0F0, 2, 0, -1);
    run_write(7'h01, 9'h100, 3, 0, -1);
    cfg_write(CFG_POLL_LIMIT, 16'd1);
    run_write(7'h3C, 9'h0C3, 2, 0, -1);
    cfg_write(CFG_POLL_LIMIT, 16'd255);
    run_write(7'h40, 9'h080, 1, 20, -1);
  endtask

  // Register extremes, zero timing, a slow timing
  task automatic test_register_extremes();
    cfg_write(CFG_DEV_ADDR, 16'd0);
    cfg_write(CFG_TICKS, 16'd0);
    run_write(7'h2B, 9'h1D2, 0, 10, -1);
    cfg_write(CFG_DEV_ADDR, 16'd255);
    cfg_write(CFG_TICKS, 16'd65535);
    idle_ticks(6);
    cfg_write(CFG_TICKS, 16'd2);
    cfg_write(CFG_POLL_LIMIT, 16'd3);
    run_write(7'h7F, 9'h000, 0, 40, -1);
    cfg_write(CFG_TICKS, 16'd1);
    cfg_write(CFG_DEV_ADDR, 16'd52);
  endtask

  // Sender stops mid-write until the block has caught up
  task automatic test_drain_pause();
    run_write(7'h33, 9'h155, 0, 20, 25);
  endtask

  // Random writes until the overall tick budget is spent
  task automatic test_random_traffic();
    int sel;
    int nack;
    while (ticks_sent < RANDOM_TICKS) begin
      if ($urandom_range(0, 3) == 0) begin
        sel = $urandom_range(0, 2);
        case (sel)
          0: cfg_write(CFG_DEV_ADDR, 16'($urandom_range(0, 255)));
          1: cfg_write(CFG_POLL_LIMIT, ($urandom_range(0, 9) == 0) ? 16'd255 :
                                       16'($urandom_range(0, 6)));
          default: cfg_write(CFG_TICKS, 16'($urandom_range(0, 2)));
        endcase
      end
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) idle_ticks($urandom_range(1, 5));
      nack = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
      run_write(7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)), nack,
                $urandom_range(0, 60), ($urandom_range(0, 19) == 0) ? 30 : -1);
    end
  endtask

  // Result ready with random stalls
  always @(negedge clk) begin
    if (rst || !stall_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        m_tready <= 1'b1;
      end else if (stall_pick < 95) begin
        stall_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        m_tready <= 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), -1);
      end else begin
        want_lv = pending_levels.pop_front();
        got_lv  = res_t'(m_tdata[6:0]);
        if (got_lv.scl !== want_lv.scl)
          report_mismatch("scl", got_lv.scl, want_lv.scl);
        if (got_lv.sda_out !== want_lv.sda_out)
          report_mismatch("sda_out", got_lv.sda_out, want_lv.sda_out);
        if (got_lv.sda_drive !== want_lv.sda_drive)
          report_mismatch("sda_drive", got_lv.sda_drive, want_lv.sda_drive);
        if (got_lv.busy_res !== want_lv.busy_res)
          report_mismatch("busy_res", got_lv.busy_res, want_lv.busy_res);
        if (got_lv.done_res !== want_lv.done_res)
          report_mismatch("done_res", got_lv.done_res, want_lv.done_res);
        if (got_lv.status !== want_lv.status)
          report_mismatch("status", got_lv.status, want_lv.status);
        if (m_tdata[7] !== 1'b0)
          report_mismatch("tdata pad", m_tdata[7], 0);
      end
    end
  end

  // Watchdog on cycles with no item moving on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    dev_byte    = DEV_ADDR_RESET;
    poll_limit  = POLL_LIMIT_RESET;
    phase_ticks = TICKS_RESET;
    bp          = S_IDLE;
    bits_sent   = '0;
    byte_i      = '0;
    shifter     = '0;
    payload     = '0;
    polls       = '0;
    timer       = '0;
    err_code    = STATUS_OK;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_write();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_nack_per_byte();
    test_register_extremes();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Covered %0d ticks, %0d results, %0d writes, %0d register updates",
             ticks_sent, results_seen, writes_begun, cfg_writes);
    $display("Write outcomes: ok %0d, address nack %0d, data nack %0d/%0d",
             done_ok, done_nack[STATUS_ADDR_NACK], done_nack[STATUS_D0_NACK],
             done_nack[STATUS_D1_NACK]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
